@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the linearizer RTL, used by gsl_back.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define GSL_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("gsl assertion failed");
`define GSL_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("gsl assertion failed");
`endif

@@ hw/rtl/gsl_pkg.sv @@
// Package for the gas sensor ppm linearizer: register codes, config and divider types,
// and the constant functions behind the exp2 factor table. No dependencies.
`timescale 1ns / 1ps
package gsl_pkg;
	localparam int DIV_W      = 64;
	localparam int EXP_Q      = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADC_REF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_RATIO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAN_RATIO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_SCALE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_EXP    = 3'd7;

	localparam logic [7:0]  RST_SAMPLE_COUNT = 8'd10;
	localparam logic [12:0] RST_ADC_REF      = 13'd3300;
	localparam logic [15:0] RST_DIV_RATIO    = 16'd4096;
	localparam logic [13:0] RST_SUPPLY       = 14'd5000;
	localparam logic [19:0] RST_LOAD_RES     = 20'd10000;
	localparam logic [15:0] RST_CLEAN_RATIO  = 16'd1126;
	localparam logic [23:0] RST_CURVE_SCALE  = 24'd582943;
	localparam logic [19:0] RST_CURVE_EXP    = 20'd102883;

	typedef struct packed {
		logic [7:0]  sample_count;
		logic [12:0] adc_ref_mv;
		logic [15:0] divider_ratio_q12;
		logic [13:0] supply_mv;
		logic [19:0] load_res_ohm;
		logic [15:0] clean_air_ratio_q8;
		logic [23:0] curve_scale_q16;
		logic [19:0] curve_exponent_q16;
	} gsl_cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} gsl_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} gsl_div_rsp_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = v;
		r   = '0;
		b   = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] exp2_factor(input int j);
		logic [63:0] s;
		s = 64'd2 << EXP_Q;
		for (int k = 0; k < j; k++) begin
			s = isqrt64(s << EXP_Q);
		end
		return s[31:0];
	endfunction
endpackage

@@ hw/rtl/gsl_front.sv @@
// Front end: sums accepted samples and emits one word per finished average.
// Does not use gsl_pkg; feeds gsl_fifo.
`timescale 1ns / 1ps
module gsl_front #(
	parameter int ADC_BITS    = 12,
	parameter int MAX_SAMPLES = 255,
	parameter int SUM_W       = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [ADC_BITS-1:0] raw_sample,
	input  logic [7:0]          sample_count,
	output logic                enq,
	output logic [SUM_W+7:0]    enq_data
);
	logic [SUM_W-1:0] sum_q;
	logic [7:0]       idx_q;
	logic [7:0]       n_lim;
	logic [7:0]       idx_inc;
	logic [SUM_W-1:0] sum_nx;
	logic             done;

	always_comb begin
		n_lim = (sample_count == 8'd0) ? 8'd1 : sample_count;
		if (n_lim > 8'(MAX_SAMPLES)) begin
			n_lim = 8'(MAX_SAMPLES);
		end
		idx_inc = idx_q + 8'd1;
		if (idx_inc == 8'd0) begin
			idx_inc = 8'd1;
		end
		sum_nx = sum_q + SUM_W'(raw_sample);
		done   = idx_inc >= n_lim;
	end

	assign enq      = accept && done;
	assign enq_data = {sum_nx, idx_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			if (done) begin
				sum_q <= '0;
				idx_q <= '0;
			end else begin
				sum_q <= sum_nx;
				idx_q <= idx_inc;
			end
		end
	end
endmodule

@@ hw/rtl/gsl_fifo.sv @@
// Two-entry queue between the front end and the back end.
// Standalone; no package use.
`timescale 1ns / 1ps
module gsl_fifo #(
	parameter int W = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         wr;
	logic         rd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rp_q];
	assign wr    = push && !full;
	assign rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

@@ hw/rtl/gsl_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on gsl_pkg for the request and response types.
`timescale 1ns / 1ps
module gsl_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gsl_pkg::gsl_div_req_t req,
	output gsl_pkg::gsl_div_rsp_t rsp
);
	import gsl_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] q_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   r_sh;
	logic             ge;

	assign r_sh = {r_q[DIV_W-1:0], q_q[DIV_W-1]};
	assign ge   = r_sh >= {1'b0, d_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = q_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			d_q <= req.divisor;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[DIV_W-2:0], ge};
			r_q <= ge ? (r_sh - {1'b0, d_q}) : r_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ hw/rtl/gsl_back.sv @@
// Back end: sequencer from average to resistance, ratio, log2, exp2 and ppm,
// with the result register. Depends on gsl_pkg and assert_macros.svh; drives gsl_div through its ports.
`timescale 1ns / 1ps
module gsl_back #(
	parameter int ADC_BITS  = 12,
	parameter int FRAC_BITS = 16,
	parameter int SUM_W     = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gsl_pkg::gsl_cfg_t     cfg,
	input  logic                  q_empty,
	input  logic [SUM_W+7:0]      q_data,
	output logic                  q_pop,
	output gsl_pkg::gsl_div_req_t div_req,
	input  gsl_pkg::gsl_div_rsp_t div_rsp,
	output logic [31:0]           ppm_q8,
	output logic [23:0]           sensor_res_ohm,
	output logic                  calibrated_now,
	output logic                  empty,
	input  logic                  pop
);
	import gsl_pkg::*;
	`include "assert_macros.svh"

	localparam int F      = FRAC_BITS;
	localparam int PV_W   = 13 + ADC_BITS;
	localparam int VADC_W = 13 + F;
	localparam int SUP_W  = 14 + F;
	localparam int RSP_W  = 20 + SUP_W;
	localparam int M_W    = F + 1;
	localparam int L_W    = 7 + F;
	localparam int Y_PW   = L_W + 21;
	localparam int T_W    = L_W + 6;
	localparam int IP_W   = T_W - F;
	localparam int KW     = $clog2(F);

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_AVG_W = 17'h00002,
		ST_VADC  = 17'h00004,
		ST_VN_GO = 17'h00008,
		ST_VN_W  = 17'h00010,
		ST_RS_MUL = 17'h00020,
		ST_RS_GO = 17'h00040,
		ST_RS_W  = 17'h00080,
		ST_X_MUL = 17'h00100,
		ST_X_GO  = 17'h00200,
		ST_X_W   = 17'h00400,
		ST_NORM  = 17'h00800,
		ST_LOG   = 17'h01000,
		ST_Y_MUL = 17'h02000,
		ST_EXP   = 17'h04000,
		ST_FIN   = 17'h08000,
		ST_OUT   = 17'h10000
	} gsl_state_t;

	gsl_state_t state_q;

	logic [ADC_BITS-1:0]   avg_q;
	logic [VADC_W-1:0]     vadc_q;
	logic [SUP_W-1:0]      vnode_q;
	logic [DIV_W-1:0]      num_q;
	logic [DIV_W-1:0]      den_q;
	logic [31:0]           rs_q;
	logic [31:0]           base_q;
	logic                  cal_q;
	logic                  now_q;
	logic [63:0]           xs_q;
	logic [5:0]            msb_q;
	logic [M_W-1:0]        m_q;
	logic [F-1:0]          frac_q;
	logic [KW-1:0]         k_q;
	logic signed [IP_W-1:0] ip_q;
	logic [F-1:0]          fr_q;
	logic [31:0]           er_q;
	logic [31:0]           ppm_q;
	logic                  oval_q;

	logic [13:0]           sup_v;
	logic [15:0]           ratio_v;
	logic [15:0]           clean_v;
	logic [SUP_W-1:0]      supq;
	logic [PV_W-1:0]       pv;
	logic [PV_W+F-1:0]     vt;
	logic [VADC_W-1:0]     vadc_w;
	logic [SUP_W-1:0]      vn_w;
	logic [RSP_W-1:0]      rs_prod;
	logic [31:0]           rs_w;
	logic [55:0]           xnum;
	logic [47:0]           xden;
	logic [2*M_W-1:0]      sq;
	logic signed [L_W-1:0]  lval;
	logic signed [Y_PW-1:0] yprod;
	logic signed [T_W-1:0]  tval;
	logic [31:0]           fact;
	logic [63:0]           eprod;
	logic [63:0]           pw_full;
	logic [IP_W-1:0]       neg;
	logic [31:0]           ppm_fin;
	logic                  ld;
	logic                  k_last;
	logic [31:0]           fact_tab [F];

	for (genvar g = 0; g < F; g++) begin : g_fact
		assign fact_tab[g] = exp2_factor(g + 1);
	end

	always_comb begin
		sup_v   = (cfg.supply_mv == 14'd0) ? 14'd1 : cfg.supply_mv;
		ratio_v = (cfg.divider_ratio_q12 == 16'd0) ? 16'd1 : cfg.divider_ratio_q12;
		clean_v = (cfg.clean_air_ratio_q8 == 16'd0) ? 16'd1 : cfg.clean_air_ratio_q8;
		supq    = {sup_v, {F{1'b0}}};

		pv     = cfg.adc_ref_mv * avg_q;
		vt     = {pv, {F{1'b0}}} >> ADC_BITS;
		vadc_w = vt[VADC_W-1:0];
		if (vadc_w == '0) begin
			vadc_w = VADC_W'(1) << F;
		end

		if (div_rsp.quot >= DIV_W'(supq)) begin
			vn_w = supq - (SUP_W'(1) << F);
		end else begin
			vn_w = div_rsp.quot[SUP_W-1:0];
		end
		if (vn_w == '0) begin
			vn_w = SUP_W'(1);
		end

		rs_prod = cfg.load_res_ohm * (supq - vnode_q);
		rs_w    = (div_rsp.quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_rsp.quot[31:0];
		xnum    = cfg.curve_scale_q16 * base_q;
		xden    = clean_v * rs_q;
		sq      = m_q * m_q;

		lval  = L_W'({1'b0, msb_q, frac_q}) - (L_W'(16) << F);
		yprod = lval * $signed({1'b0, cfg.curve_exponent_q16});
		tval  = T_W'(yprod >>> 16) + (T_W'(8) << F);

		fact    = fact_tab[k_q];
		eprod   = er_q * fact;
		k_last  = k_q == KW'(F - 1);

		pw_full = {32'd0, er_q} << ip_q[4:0];
		neg     = IP_W'(0) - ip_q;
		if (!ip_q[IP_W-1]) begin
			if (ip_q[IP_W-2:5] != '0) begin
				ppm_fin = 32'hFFFF_FFFF;
			end else if (pw_full[63:62] != 2'b00) begin
				ppm_fin = 32'hFFFF_FFFF;
			end else begin
				ppm_fin = pw_full[61:30];
			end
		end else if (neg[IP_W-1:5] != '0) begin
			ppm_fin = 32'd0;
		end else begin
			ppm_fin = (er_q >> EXP_Q) >> neg[4:0];
		end

		ld = (state_q == ST_OUT) && (!oval_q || pop);
	end

	always_comb begin
		div_req = '0;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop            = 1'b1;
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(q_data[SUM_W+7:8]);
					div_req.divisor  = DIV_W'(q_data[7:0]);
				end
			end
			ST_VN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'({vadc_q, 12'd0});
				div_req.divisor  = DIV_W'(ratio_v);
			end
			ST_RS_GO, ST_X_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = num_q;
				div_req.divisor  = den_q;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cal_q   <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			if (ld) begin
				oval_q <= 1'b1;
			end else if (pop) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (!q_empty) state_q <= ST_AVG_W;
				ST_AVG_W:  if (div_rsp.done) state_q <= ST_VADC;
				ST_VADC:   state_q <= ST_VN_GO;
				ST_VN_GO:  state_q <= ST_VN_W;
				ST_VN_W:   if (div_rsp.done) state_q <= ST_RS_MUL;
				ST_RS_MUL: state_q <= ST_RS_GO;
				ST_RS_GO:  state_q <= ST_RS_W;
				ST_RS_W: begin
					if (div_rsp.done) begin
						cal_q   <= 1'b1;
						state_q <= (rs_w == 32'd0) ? ST_OUT : ST_X_MUL;
					end
				end
				ST_X_MUL:  state_q <= ST_X_GO;
				ST_X_GO:   state_q <= ST_X_W;
				ST_X_W: begin
					if (div_rsp.done) begin
						state_q <= (div_rsp.quot == '0) ? ST_OUT : ST_NORM;
					end
				end
				ST_NORM:   if (xs_q[63]) state_q <= ST_LOG;
				ST_LOG:    if (k_last) state_q <= ST_Y_MUL;
				ST_Y_MUL:  state_q <= ST_EXP;
				ST_EXP:    if (k_last) state_q <= ST_FIN;
				ST_FIN:    state_q <= ST_OUT;
				ST_OUT:    if (ld) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ppm_q8         <= ppm_q;
			sensor_res_ohm <= (rs_q[31:24] != 8'd0) ? 24'hFF_FFFF : rs_q[23:0];
			calibrated_now <= now_q;
		end
		unique case (state_q)
			ST_AVG_W: if (div_rsp.done) avg_q <= div_rsp.quot[ADC_BITS-1:0];
			ST_VADC:  vadc_q <= vadc_w;
			ST_VN_W:  if (div_rsp.done) vnode_q <= vn_w;
			ST_RS_MUL: begin
				num_q <= DIV_W'(rs_prod);
				den_q <= DIV_W'(vnode_q);
			end
			ST_RS_W: begin
				if (div_rsp.done) begin
					rs_q  <= rs_w;
					now_q <= !cal_q;
					ppm_q <= 32'hFFFF_FFFF;
					if (!cal_q) begin
						base_q <= rs_w;
					end
				end
			end
			ST_X_MUL: begin
				num_q <= {xnum, 8'd0};
				den_q <= DIV_W'(xden);
			end
			ST_X_W: begin
				if (div_rsp.done) begin
					xs_q  <= div_rsp.quot;
					msb_q <= 6'd63;
					ppm_q <= 32'd0;
				end
			end
			ST_NORM: begin
				if (xs_q[63]) begin
					m_q <= xs_q[63 -: M_W];
					k_q <= '0;
				end else begin
					xs_q  <= {xs_q[62:0], 1'b0};
					msb_q <= msb_q - 6'd1;
				end
			end
			ST_LOG: begin
				if (sq[2*F+1]) begin
					m_q <= sq[2*F+1:F+1];
				end else begin
					m_q <= sq[2*F:F];
				end
				frac_q <= {frac_q[F-2:0], sq[2*F+1]};
				k_q    <= k_q + KW'(1);
			end
			ST_Y_MUL: begin
				ip_q <= tval[T_W-1:F];
				fr_q <= tval[F-1:0];
				er_q <= 32'd1 << EXP_Q;
				k_q  <= '0;
			end
			ST_EXP: begin
				if (fr_q[F-1]) begin
					er_q <= eprod[61:30];
				end
				fr_q <= {fr_q[F-2:0], 1'b0};
				k_q  <= k_q + KW'(1);
			end
			ST_FIN: ppm_q <= ppm_fin;
			default: begin
			end
		endcase
	end

	assign empty = !oval_q;

	`GSL_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy)
	`GSL_ASSERT_IMP(a_div_done_wait, div_rsp.done,
		state_q == ST_AVG_W || state_q == ST_VN_W || state_q == ST_RS_W || state_q == ST_X_W)
	`GSL_ASSERT_IMP(a_cal_before_now, oval_q && calibrated_now, cal_q)
	`GSL_ASSERT_NEXT(a_cal_sticky, cal_q, cal_q)
endmodule

@@ hw/rtl/gas_sensor_ppm_linearizer.sv @@
// Top level of the gas sensor ppm linearizer: config registers, front end, queue,
// shared divider and back end. Depends on gsl_pkg and all gsl_* modules.
//
// Usage:
//  Input channel: drive raw_sample with push; a word is taken when push is high and
//  full is low. Every sample_count words (1 when zero, capped at MAX_SAMPLES) close
//  one average, which waits in a two-entry queue for the back end.
//  Result channel: while empty is low, ppm_q8, sensor_res_ohm and calibrated_now
//  hold the oldest result; pop takes it. One result per closed average.
//  Config: cfg_write with cfg_index and cfg_data writes one register per cycle;
//  write only while the block is idle.
//  Sequence: an average takes 4 divider passes, a normalize shift loop, 2*FRAC_BITS
//  log2/exp2 steps and the control states; a zero resistance ends after the third
//  divider pass, a zero ratio after the fourth.
//  Input words that do not close an average are taken every cycle while the queue
//  has room; full rises when two averages are waiting.
//  A stalled receiver holds the result register; the back end finishes the next
//  average and then waits, and the queue keeps taking input until it fills.
//  Reset restores all config defaults, clears the running sum and the calibrated
//  flag; the first result afterwards captures the clean-air base resistance.
`timescale 1ns / 1ps
module gas_sensor_ppm_linearizer #(
	parameter int ADC_BITS    = 12,
	parameter int MAX_SAMPLES = 255,
	parameter int FRAC_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [ADC_BITS-1:0]                raw_sample,
	output logic                               empty,
	input  logic                               pop,
	output logic [31:0]                        ppm_q8,
	output logic [23:0]                        sensor_res_ohm,
	output logic                               calibrated_now,
	input  logic                               cfg_write,
	input  logic [gsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gsl_pkg::*;

	localparam int SUM_W = ADC_BITS + $clog2(MAX_SAMPLES + 1);

	gsl_cfg_t         cfg_q;
	logic             accept;
	logic             enq;
	logic [SUM_W+7:0] enq_data;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [SUM_W+7:0] q_data;
	gsl_div_req_t     div_req;
	gsl_div_rsp_t     div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count       <= RST_SAMPLE_COUNT;
			cfg_q.adc_ref_mv         <= RST_ADC_REF;
			cfg_q.divider_ratio_q12  <= RST_DIV_RATIO;
			cfg_q.supply_mv          <= RST_SUPPLY;
			cfg_q.load_res_ohm       <= RST_LOAD_RES;
			cfg_q.clean_air_ratio_q8 <= RST_CLEAN_RATIO;
			cfg_q.curve_scale_q16    <= RST_CURVE_SCALE;
			cfg_q.curve_exponent_q16 <= RST_CURVE_EXP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT: cfg_q.sample_count       <= cfg_data[7:0];
				REG_ADC_REF:      cfg_q.adc_ref_mv         <= cfg_data[12:0];
				REG_DIV_RATIO:    cfg_q.divider_ratio_q12  <= cfg_data[15:0];
				REG_SUPPLY:       cfg_q.supply_mv          <= cfg_data[13:0];
				REG_LOAD_RES:     cfg_q.load_res_ohm       <= cfg_data[19:0];
				REG_CLEAN_RATIO:  cfg_q.clean_air_ratio_q8 <= cfg_data[15:0];
				REG_CURVE_SCALE:  cfg_q.curve_scale_q16    <= cfg_data[23:0];
				REG_CURVE_EXP:    cfg_q.curve_exponent_q16 <= cfg_data[19:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	gsl_front #(
		.ADC_BITS   (ADC_BITS),
		.MAX_SAMPLES(MAX_SAMPLES),
		.SUM_W      (SUM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.raw_sample  (raw_sample),
		.sample_count(cfg_q.sample_count),
		.enq         (enq),
		.enq_data    (enq_data)
	);

	gsl_fifo #(
		.W(SUM_W + 8)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (enq),
		.din   (enq_data),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_data),
		.empty (q_empty)
	);

	gsl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	gsl_back #(
		.ADC_BITS (ADC_BITS),
		.FRAC_BITS(FRAC_BITS),
		.SUM_W    (SUM_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.ppm_q8        (ppm_q8),
		.sensor_res_ohm(sensor_res_ohm),
		.calibrated_now(calibrated_now),
		.empty         (empty),
		.pop           (pop)
	);
endmodule
